// ===== rtl/mlfd_pkg.sv =====
package mlfd_pkg;

    // Body buffer depth
    localparam int MAX_BODY = 256;
    localparam int ADDR_W   = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
    localparam logic [15:0] MAX_BODY_W = 16'(MAX_BODY);

    localparam logic [8:0] LIMIT_RESET = 9'd256;
    localparam logic [8:0] LEN_SAT     = 9'd511;

    localparam logic [7:0] MAGIC [4] = '{8'h01, 8'h02, 8'h03, 8'h04};

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        PH_MAGIC  = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2,
        PH_CHECK  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        K_ACCEPTED  = 2'd0,
        K_MISMATCH  = 2'd1,
        K_TOO_LARGE = 2'd2,
        K_READ      = 2'd3
    } kind_t;

    // Result of one transfer, before the buffer read data is attached
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [8:0] frame_length;
        logic       read_ok;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_req_t;

endpackage

// ===== rtl/mlfd_in_if.sv =====
interface mlfd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    logic [7:0] read_index;

    modport source (output valid, output operation, output data_byte, output read_index,
                    input ready);
    modport sink (input valid, input operation, input data_byte, input read_index,
                  output ready);
endinterface

// ===== rtl/mlfd_out_if.sv =====
interface mlfd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [8:0] frame_length;
    logic [7:0] read_data;

    modport source (output valid, output result_kind, output frame_length,
                    output read_data, input ready);
    modport sink (input valid, input result_kind, input frame_length,
                  input read_data, output ready);
endinterface

// ===== rtl/magic_length_fletcher_deframer.sv =====
// A result is registered first in stage one, together with the buffer read port, and then
//   in the output register; stage one holds its result while the output register stalls.
// Throughput: one input transfer per cycle, sustained while the output is taken.
// The body buffer's registered read port sets the extra stage before the output.
// Reset (rst_n, asynchronous, active low) clears parser state, the length limit (to 256)
//   and the pipeline valids; the body buffer is not cleared.
module magic_length_fletcher_deframer (
    input  logic       clk,
    input  logic       rst_n,
    mlfd_in_if.sink    item,
    mlfd_out_if.source result,
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata
);
    import mlfd_pkg::*;

    logic              accept;
    logic              advance;
    wr_req_t           wr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    result_t           res;

    // Stage one: result descriptor waiting for the buffer read data
    result_t           s1_reg;

    // Output register
    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [8:0]        out_len_reg;
    logic [7:0]        out_data_reg;

    // Stage one moves on whenever the output register is free or being drained,
    // so a new transfer is taken even while a finished result still waits.
    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = !s1_reg.valid || advance;
    assign accept     = item.valid && item.ready;

    mlfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (item.operation),
        .data_byte  (item.data_byte),
        .read_index (item.read_index),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .wr         (wr),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .res        (res)
    );

    // Body buffer; read data only changes on a read transfer, so it holds
    // while stage one is stalled.
    mlfd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BODY)
    ) u_body_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_reg <= res;
            end
            else if (advance)
            begin
                s1_reg.valid <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= s1_reg.valid;
            end
        end
    end

    // Payload side of the output register: no reset needed
    always_ff @(posedge clk)
    begin
        if (advance && s1_reg.valid)
        begin
            out_kind_reg <= s1_reg.kind;
            out_len_reg  <= s1_reg.frame_length;
            out_data_reg <= s1_reg.read_ok ? rd_data : 8'd0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_kind  = out_kind_reg;
    assign result.frame_length = out_len_reg;
    assign result.read_data    = out_data_reg;

    a_free_output_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> item.ready)
        else $error("input stalled with an empty output register");

    a_stalled_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid && !advance |=> s1_reg.valid && $stable(s1_reg))
        else $error("stage one result lost during output stall");

    a_read_flag_only_reads: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid && s1_reg.read_ok |-> s1_reg.kind == K_READ)
        else $error("buffer data attached to a frame result");

endmodule

// ===== rtl/mlfd_ram.sv =====
module mlfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mlfd_parser.sv =====
module mlfd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              operation,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        read_index,
    input  logic              cfg_we,
    input  logic [8:0]        cfg_wdata,
    output mlfd_pkg::wr_req_t wr,
    output logic              rd_en,
    output logic [mlfd_pkg::ADDR_W-1:0] rd_addr,
    output mlfd_pkg::result_t res
);
    import mlfd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] magic_reg, magic_next;
    logic       half_reg, half_next;
    logic [7:0] hold_reg, hold_next;
    logic [8:0] body_length_reg, body_length_next;
    logic [8:0] body_count_reg, body_count_next;
    logic [7:0] low_reg, low_next;
    logic [7:0] high_reg, high_next;
    logic [8:0] limit_reg;

    logic [15:0] word;
    logic [15:0] limit_eff;
    logic [15:0] expect_sum;

    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 9'd255) ? 8'(s - 9'd255) : s[7:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_MAGIC;
            magic_reg       <= '0;
            half_reg        <= 1'b0;
            hold_reg        <= '0;
            body_length_reg <= '0;
            body_count_reg  <= '0;
            low_reg         <= '0;
            high_reg        <= '0;
            limit_reg       <= LIMIT_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            magic_reg       <= magic_next;
            half_reg        <= half_next;
            hold_reg        <= hold_next;
            body_length_reg <= body_length_next;
            body_count_reg  <= body_count_next;
            low_reg         <= low_next;
            high_reg        <= high_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    assign word       = {hold_reg, data_byte};
    assign limit_eff  = ({7'b0, limit_reg} > MAX_BODY_W) ? MAX_BODY_W : {7'b0, limit_reg};
    assign expect_sum = {high_reg, low_reg};
    assign rd_en      = accept && (operation == OP_READ);
    assign rd_addr    = ADDR_W'(read_index);

    always_comb
    begin
        phase_next       = phase_reg;
        magic_next       = magic_reg;
        half_next        = half_reg;
        hold_next        = hold_reg;
        body_length_next = body_length_reg;
        body_count_next  = body_count_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        res              = '0;
        res.kind         = K_ACCEPTED;
        wr               = '0;

        if (accept)
        begin
            if (operation == OP_READ)
            begin
                res.valid        = 1'b1;
                res.kind         = K_READ;
                res.frame_length = body_length_reg;
                res.read_ok      = ({1'b0, read_index} < body_length_reg)
                                   && ({8'b0, read_index} < MAX_BODY_W);
            end
            else
            begin
                unique case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (data_byte == MAGIC[magic_reg])
                        begin
                            if (magic_reg == 2'd3)
                            begin
                                magic_next = '0;
                                half_next  = 1'b0;
                                phase_next = PH_LENGTH;
                            end
                            else
                            begin
                                magic_next = magic_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            // a breaking 01 may open a fresh match
                            magic_next = (data_byte == MAGIC[0]) ? 2'd1 : 2'd0;
                        end
                    end
                    PH_LENGTH:
                    begin
                        if (!half_reg)
                        begin
                            hold_next = data_byte;
                            half_next = 1'b1;
                        end
                        else
                        begin
                            half_next = 1'b0;
                            if (word > limit_eff)
                            begin
                                phase_next       = PH_MAGIC;
                                magic_next       = '0;
                                res.valid        = 1'b1;
                                res.kind         = K_TOO_LARGE;
                                res.frame_length = (word > {7'b0, LEN_SAT}) ? LEN_SAT
                                                                            : word[8:0];
                            end
                            else
                            begin
                                body_length_next = word[8:0];
                                body_count_next  = '0;
                                low_next         = '0;
                                high_next        = '0;
                                phase_next       = (word == 16'd0) ? PH_CHECK : PH_BODY;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        wr.en           = ({7'b0, body_count_reg} < MAX_BODY_W);
                        wr.addr         = ADDR_W'(body_count_reg);
                        wr.data         = data_byte;
                        low_next        = add_mod255(low_reg, data_byte);
                        high_next       = add_mod255(high_reg, low_next);
                        body_count_next = body_count_reg + 9'd1;
                        if (body_count_next >= body_length_reg)
                        begin
                            phase_next = PH_CHECK;
                            half_next  = 1'b0;
                        end
                    end
                    PH_CHECK:
                    begin
                        if (!half_reg)
                        begin
                            hold_next = data_byte;
                            half_next = 1'b1;
                        end
                        else
                        begin
                            phase_next       = PH_MAGIC;
                            magic_next       = '0;
                            half_next        = 1'b0;
                            res.valid        = 1'b1;
                            res.kind         = (word == expect_sum) ? K_ACCEPTED : K_MISMATCH;
                            res.frame_length = body_length_reg;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_MAGIC;
                    end
                endcase
            end
        end
    end

    a_magic_half_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_MAGIC |-> !half_reg)
        else $error("length/checksum byte pairing left open while hunting for magic");

    a_write_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> accept && operation == OP_PUSH && phase_reg == PH_BODY)
        else $error("buffer write outside body phase");

    a_reject_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == K_TOO_LARGE |=> phase_reg == PH_MAGIC && magic_reg == 2'd0)
        else $error("oversize length did not restart the magic search");

    a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg != 8'hFF && high_reg != 8'hFF)
        else $error("Fletcher sum not reduced modulo 255");

endmodule

// ===== test/mlfd_frame_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels and the limit register, keeps its own copy of the
// parser state and compares every result transfer with the oldest prediction.
module mlfd_frame_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    mlfd_in_if                            in_ch,
    mlfd_out_if                           out_ch,
    input  logic                          cfg_we,
    input  logic [8:0]                    cfg_wdata,
    output int                            fail_count,
    output int                            awaiting,
    output logic [8:0]                    body_len_now,
    output logic [mlfd_pkg::MAX_BODY-1:0] stored_mask,
    output int                            n_accepted,
    output int                            n_mismatch,
    output int                            n_too_large,
    output int                            n_read
);
    import mlfd_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [8:0] frame_length;
        logic [7:0] read_data;
    } frame_result_t;

    frame_result_t due_q [$];
    frame_result_t want;

    logic [8:0] limit_q;
    phase_t     phase_q;
    logic [1:0] magic_cnt;
    logic       half_q;
    logic [7:0] hold_q;
    logic [8:0] blen_q;
    logic [8:0] bcnt_q;
    logic [7:0] sum_lo;
    logic [7:0] sum_hi;
    logic [7:0] body_mem [MAX_BODY];

    assign body_len_now = blen_q;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_v);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_v);
        fail_count++;
    endtask

    task automatic restart_hunt();
        phase_q   = PH_MAGIC;
        magic_cnt = 2'd0;
        half_q    = 1'b0;
    endtask

    task automatic queue_result(input kind_t k, input logic [8:0] len, input logic [7:0] d);
        due_q.push_back('{k, len, d});
    endtask

    // One accepted input transfer
    task automatic deframe_step(input logic op, input logic [7:0] b, input logic [7:0] idx);
        logic [15:0] announced;
        logic [8:0]  eff_limit;
        int          acc;
        if (op == OP_READ)
        begin
            queue_result(K_READ, blen_q, (9'(idx) < blen_q) ? body_mem[idx] : 8'h00);
            return;
        end
        unique case (phase_q)
            PH_MAGIC:
            begin
                if (b == MAGIC[magic_cnt])
                begin
                    if (magic_cnt == 2'd3)
                    begin
                        magic_cnt = 2'd0;
                        half_q    = 1'b0;
                        phase_q   = PH_LENGTH;
                    end
                    else
                        magic_cnt = magic_cnt + 2'd1;
                end
                else
                    magic_cnt = (b == MAGIC[0]) ? 2'd1 : 2'd0;
            end
            PH_LENGTH:
            begin
                if (!half_q)
                begin
                    hold_q = b;
                    half_q = 1'b1;
                end
                else
                begin
                    half_q    = 1'b0;
                    announced = {hold_q, b};
                    eff_limit = (limit_q > 9'(MAX_BODY)) ? 9'(MAX_BODY) : limit_q;
                    if (announced > 16'(eff_limit))
                    begin
                        restart_hunt();
                        queue_result(K_TOO_LARGE,
                                     (announced > 16'(LEN_SAT)) ? LEN_SAT : announced[8:0],
                                     8'h00);
                    end
                    else
                    begin
                        blen_q  = announced[8:0];
                        bcnt_q  = 9'd0;
                        sum_lo  = 8'd0;
                        sum_hi  = 8'd0;
                        phase_q = (announced == 16'd0) ? PH_CHECK : PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if (bcnt_q < 9'(MAX_BODY))
                begin
                    body_mem[bcnt_q[ADDR_W-1:0]]    = b;
                    stored_mask[bcnt_q[ADDR_W-1:0]] = 1'b1;
                end
                acc    = (int'(sum_lo) + int'(b)) % 255;
                sum_lo = 8'(acc);
                acc    = (int'(sum_hi) + int'(sum_lo)) % 255;
                sum_hi = 8'(acc);
                bcnt_q = bcnt_q + 9'd1;
                if (bcnt_q >= blen_q)
                begin
                    phase_q = PH_CHECK;
                    half_q  = 1'b0;
                end
            end
            PH_CHECK:
            begin
                if (!half_q)
                begin
                    hold_q = b;
                    half_q = 1'b1;
                end
                else
                begin
                    restart_hunt();
                    queue_result(({hold_q, b} == {sum_hi, sum_lo}) ? K_ACCEPTED : K_MISMATCH,
                                 blen_q, 8'h00);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_q = LIMIT_RESET;
            restart_hunt();
            hold_q      = 8'd0;
            blen_q      = 9'd0;
            bcnt_q      = 9'd0;
            sum_lo      = 8'd0;
            sum_hi      = 8'd0;
            stored_mask = '0;
            due_q.delete();
            fail_count  = 0;
            awaiting    = 0;
            n_accepted  = 0;
            n_mismatch  = 0;
            n_too_large = 0;
            n_read      = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (due_q.size() == 0)
                    report_mismatch("unexpected result, kind", 16'(out_ch.result_kind), 16'hFFFF);
                else
                begin
                    want = due_q.pop_front();
                    if (out_ch.result_kind !== want.kind)
                        report_mismatch("result_kind", 16'(out_ch.result_kind), 16'(want.kind));
                    if (out_ch.frame_length !== want.frame_length)
                        report_mismatch("frame_length", 16'(out_ch.frame_length),
                                        16'(want.frame_length));
                    if (out_ch.read_data !== want.read_data)
                        report_mismatch("read_data", 16'(out_ch.read_data), 16'(want.read_data));
                    unique case (want.kind)
                        K_ACCEPTED:  n_accepted++;
                        K_MISMATCH:  n_mismatch++;
                        K_TOO_LARGE: n_too_large++;
                        K_READ:      n_read++;
                    endcase
                end
            end
            if (cfg_we)
                limit_q = cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                deframe_step(in_ch.operation, in_ch.data_byte, in_ch.read_index);
            awaiting = due_q.size();
        end
    end

endmodule

// ===== test/tb_magic_length_fletcher_deframer.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the deframer. Prediction and comparison live in
// the frame checker beside the block; this module only makes traffic.
module tb_magic_length_fletcher_deframer;
    import mlfd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 3;
    localparam int PHASE_ITEMS   = 110;     // random transfers per limit setting
    localparam int HOLD_CYCLES   = 300;     // long result back-pressure stretch
    localparam int HOLD_READS    = 40;      // reads offered during that stretch
    localparam int SETTLE_CYCLES = 6;       // margin for the result pipeline to drain
    localparam int CYCLE_LIMIT   = 400000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [8:0] cfg_wdata = 9'd0;

    mlfd_in_if  item_ch ();
    mlfd_out_if result_ch ();

    // Checker outputs
    int                  fail_total;
    int                  awaiting;
    logic [8:0]          body_len_now;
    logic [MAX_BODY-1:0] stored_mask;
    int                  n_accepted;
    int                  n_mismatch;
    int                  n_too_large;
    int                  n_read;

    // Sender shaping and bookkeeping
    bit         steady      = 1'b0;     // no gaps between transfers
    int         burst_left  = 0;
    int         items_sent  = 0;
    int         settings    = 0;
    int         hold_asked  = 0;        // bumped by stimulus
    int         hold_served = 0;        // bumped by the result sink

    always #(CLK_PERIOD / 2) clk = ~clk;

    magic_length_fletcher_deframer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    mlfd_frame_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (item_ch),
        .out_ch       (result_ch),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_total),
        .awaiting     (awaiting),
        .body_len_now (body_len_now),
        .stored_mask  (stored_mask),
        .n_accepted   (n_accepted),
        .n_mismatch   (n_mismatch),
        .n_too_large  (n_too_large),
        .n_read       (n_read)
    );

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one item and hold it until the transfer. Called at a falling
    // edge and returns at the falling edge after the transfer, so valid
    // stays high across back-to-back items with a single assignment.
    task automatic send_item(input logic op, input logic [7:0] b, input logic [7:0] idx);
        int gap;
        if (!steady && burst_left <= 0)
        begin
            gap = $urandom_range(6, 1);
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(24, 1);
        end
        item_ch.valid      <= 1'b1;
        item_ch.operation  <= op;
        item_ch.data_byte  <= b;
        item_ch.read_index <= idx;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    // A buffer read at an index whose answer is defined: either beyond the
    // current body length (reads as zero) or an entry written by some frame.
    // The checker state is current here, as every earlier transfer is done.
    task automatic read_random();
        logic [7:0] idx;
        int         tries;
        bit         legal;
        legal = 1'b0;
        idx   = 8'd0;
        for (tries = 0; tries < 16 && !legal; tries++)
        begin
            if (body_len_now != 9'd0 && $urandom_range(3) != 0)
                idx = 8'($urandom_range(int'(body_len_now) - 1, 0));
            else
                idx = 8'($urandom);
            legal = (9'(idx) >= body_len_now) || stored_mask[idx];
        end
        if (legal)
            send_item(OP_READ, 8'($urandom), idx);
    endtask

    // Magic then the big-endian body length
    task automatic send_header(input logic [15:0] len);
        for (int k = 0; k < 4; k++)
            send_item(OP_PUSH, MAGIC[k], 8'($urandom));
        send_item(OP_PUSH, len[15:8], 8'($urandom));
        send_item(OP_PUSH, len[7:0], 8'($urandom));
    endtask

    // Whole frame with a Fletcher-16 trailer, optionally spoilt, and with
    // buffer reads mixed into the body now and then
    task automatic send_frame(input int len, input bit corrupt, input int read_pct);
        logic [7:0]  b;
        logic [15:0] sum;
        int          lo;
        int          hi;
        lo = 0;
        hi = 0;
        send_header(16'(len));
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            send_item(OP_PUSH, b, 8'($urandom));
            lo = (lo + int'(b)) % 255;
            hi = (hi + lo) % 255;
            if ($urandom_range(99) < read_pct)
                read_random();
        end
        sum = {8'(hi), 8'(lo)};
        if (corrupt)
            sum = sum ^ 16'($urandom_range(16'hFFFF, 1));
        send_item(OP_PUSH, sum[15:8], 8'($urandom));
        send_item(OP_PUSH, sum[7:0], 8'($urandom));
    endtask

    // Drop valid and wait for every predicted result, then let the pipeline
    // settle, since pushes leave nothing in the checker to wait on
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only ever called with the block idle
    task automatic write_limit(input logic [8:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    // One limit setting: frames with random bodies, most with a good trailer, the rest
    // oversize headers, noise, broken sequences and bursts of reads
    task automatic run_phase(input logic [8:0] lim, input bit full_frame, input bit with_hold);
        int start;
        int pick;
        int pick2;
        int eff;
        int len;
        int k;
        wait_idle();
        write_limit(lim);
        eff    = (int'(lim) > MAX_BODY) ? MAX_BODY : int'(lim);
        steady = ($urandom_range(3) == 0);
        start  = items_sent;

        // largest body the buffer takes, only where the limit allows it
        if (full_frame)
            send_frame(MAX_BODY, 1'b0, 2);

        // Receiver holds off while reads keep coming: the pipeline fills
        // and the input stalls. Then a pause until all results are back.
        if (with_hold)
        begin
            hold_asked++;
            steady = 1'b1;
            repeat (HOLD_READS) read_random();
            steady = 1'b0;
            wait_idle();
        end

        while (items_sent - start < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                pick2 = $urandom_range(9);
                if (pick2 == 0 && eff <= 64)
                    len = eff;
                else if (pick2 == 1)
                    len = $urandom_range((eff < 48) ? eff : 48, 0);
                else
                    len = $urandom_range((eff < 12) ? eff : 12, 0);
                send_frame(len, ($urandom_range(4) == 0), 15);
            end
            else if (pick < 65)
            begin
                // announced length over the limit
                pick2 = $urandom_range(3);
                if (pick2 < 2)
                    len = eff + $urandom_range(8, 1);
                else if (pick2 == 2)
                    len = $urandom_range(16'hFFFF, 257);
                else
                    len = 16'hFFFF;
                send_header(16'(len));
            end
            else if (pick < 77)
            begin
                // noise, rich in bytes that look like magic
                repeat ($urandom_range(6, 1))
                begin
                    if ($urandom_range(1) == 0)
                        send_item(OP_PUSH, 8'($urandom), 8'($urandom));
                    else
                        send_item(OP_PUSH, 8'($urandom_range(4, 1)), 8'($urandom));
                end
            end
            else if (pick < 82 && eff > 0)
            begin
                // frame cut short: the parser eats what follows as body
                len = $urandom_range((eff < 12) ? eff : 12, 1);
                send_header(16'(len));
                repeat ($urandom_range(len - 1, 0))
                    send_item(OP_PUSH, 8'($urandom), 8'($urandom));
            end
            else if (pick < 88)
            begin
                // partial magic broken by a random byte
                k = $urandom_range(3, 1);
                for (int j = 0; j < k; j++)
                    send_item(OP_PUSH, MAGIC[j], 8'($urandom));
                send_item(OP_PUSH, 8'($urandom), 8'($urandom));
            end
            else
                repeat ($urandom_range(5, 1)) read_random();
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink: a rotating ready pattern, redrawn now and then, with
    // stretches of always-ready, and the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        logic [15:0] pattern;
        int          age;
        result_ch.ready = 1'b0;
        pattern = 16'hFFFF;
        age     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_asked)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_served++;
            end
            else
            begin
                if (age == 0)
                begin
                    age     = $urandom_range(96, 16);
                    pattern = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
                    if (pattern == 16'h0000)
                        pattern = 16'h0001;
                end
                age--;
                result_ch.ready <= pattern[0];
                pattern = {pattern[0], pattern[15:1]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: far beyond the slowest correct run
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("watchdog: run still busy after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, awaiting);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        // Directed opener, under the reset limit:
        //  - magic broken by a non-01 byte, then a zero-length frame with a
        //    wrong trailer (checksum of an empty body is 0000)
        //  - magic broken by 01 part way, which restarts the match, then a
        //    one-byte body of FF whose checksum folds to 0000
        //  - announced length FFFF, reported saturated
        logic [7:0] opening [27] = '{
            8'h01, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h00, 8'h12, 8'h34,
            8'h01, 8'h02, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00,
            8'h01, 8'h02, 8'h03, 8'h04, 8'hFF, 8'hFF
        };

        item_ch.valid      = 1'b0;
        item_ch.operation  = OP_PUSH;
        item_ch.data_byte  = 8'h00;
        item_ch.read_index = 8'h00;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // read before any frame: body length still zero
        send_item(OP_READ, 8'hA5, 8'h00);
        foreach (opening[i])
            send_item(OP_PUSH, opening[i], 8'($urandom));
        // the oversize frame left the body length at 1
        send_item(OP_READ, 8'h5A, 8'h00);
        send_item(OP_READ, 8'h00, 8'hFF);

        // Random part across limit settings, extremes included; 511 lies
        // above the buffer so the accepted length tops out at 256
        run_phase(9'd511, 1'b1, 1'b0);
        run_phase(9'd0, 1'b0, 1'b0);
        run_phase(9'd300, 1'b0, 1'b1);
        run_phase(9'd1, 1'b0, 1'b0);
        run_phase(9'($urandom_range(63, 2)), 1'b0, 1'b0);
        run_phase(9'd255, 1'b0, 1'b0);
        run_phase(LIMIT_RESET, 1'b1, 1'b0);
        run_phase(9'($urandom_range(255, 0)), 1'b0, 1'b0);

        wait_idle();

        $display("Covered %0d input transfers under %0d limit settings, with a %0d-cycle hold-off.",
                 items_sent, settings, HOLD_CYCLES);
        $display("Results: %0d accepted, %0d checksum mismatch, %0d oversize, %0d buffer reads.",
                 n_accepted, n_mismatch, n_too_large, n_read);
        if (fail_total == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
